>>> rtl/plt_pkg.sv
// plt_pkg: shared types and codes for the positional list table.
// Used by plt_ctrl and positional_list_table; no dependencies.
package plt_pkg;

   localparam int OP_W  = 2;
   localparam int POS_W = 5;
   localparam int VAL_W = 32;
   localparam int ST_W  = 2;
   localparam int CNT_W = 5;

   localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE   = 2'd1;
   localparam logic [OP_W-1:0] OP_LOCATE   = 2'd2;
   localparam logic [OP_W-1:0] OP_RETRIEVE = 2'd3;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic              is_empty;
      logic [CNT_W-1:0]  item_count;
      logic [ST_W-1:0]   status;
      logic [POS_W-1:0]  found_position;
      logic [VAL_W-1:0]  read_value;
   } plt_rsp_type;

endpackage

>>> rtl/plt_ram.sv
// plt_ram: list storage, one write port and one read port with registered data.
// No dependencies.
module plt_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rdata_ff <= store_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/plt_ctrl.sv
// plt_ctrl: sequencer that walks the list store one entry a cycle for each operation that is not rejected.
// Depends on plt_pkg; drives the ports of plt_ram.
module plt_ctrl
   import plt_pkg::*;
#(
   parameter int CAPACITY = 16,
   parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [OP_W-1:0]  req_op,
   input  logic [POS_W-1:0] req_pos,
   input  logic [VAL_W-1:0] req_val,
   output logic             res_valid,
   input  logic             res_ready,
   output plt_rsp_type      res,
   output logic             mem_we,
   output logic [AW-1:0]    mem_waddr,
   output logic [VAL_W-1:0] mem_wdata,
   output logic [AW-1:0]    mem_raddr,
   input  logic [VAL_W-1:0] mem_rdata
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [AW-1:0]    wpos_ff, wpos_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [AW-1:0]    ptr_ff, ptr_in;
   logic [CW-1:0]    left_ff, left_in;
   logic             up_ff, up_in;
   logic             head_ff, head_in;
   logic             rdv_ff, rdv_in;
   logic [AW-1:0]    rdaddr_ff, rdaddr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [VAL_W-1:0] rd_ff, rd_in;
   logic [CW-1:0]    found_ff, found_in;
   logic [ST_W-1:0]  status_ff, status_in;

   logic [CW+4:0]    pos_x, cnt_x, found_x;
   logic [CW-1:0]    pos_c, rdaddr_c;
   logic             match;

   always_comb begin
      pos_x        = '0;
      pos_x[4:0]   = req_pos;
      cnt_x        = '0;
      cnt_x[CW-1:0] = count_ff;
      pos_c        = pos_x[CW-1:0];
      rdaddr_c     = '0;
      rdaddr_c[AW-1:0] = rdaddr_ff;
      match        = (op_ff == OP_LOCATE) && rdv_ff && (mem_rdata == val_ff);
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      wpos_in   = wpos_ff;
      val_in    = val_ff;
      ptr_in    = ptr_ff;
      left_in   = left_ff;
      up_in     = up_ff;
      head_in   = head_ff;
      rdv_in    = 1'b0;
      rdaddr_in = rdaddr_ff;
      count_in  = count_ff;
      rd_in     = rd_ff;
      found_in  = found_ff;
      status_in = status_ff;
      mem_we    = 1'b0;
      mem_waddr = rdaddr_ff;
      mem_wdata = mem_rdata;
      mem_raddr = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               val_in    = req_val;
               wpos_in   = pos_x[AW-1:0];
               rd_in     = '0;
               found_in  = '0;
               status_in = ST_OK;
               head_in   = 1'b1;
               state_in  = S_WALK;
               unique case (req_op)
                  OP_INSERT: begin
                     ptr_in  = count_ff[AW-1:0] - 1'b1;
                     left_in = count_ff - pos_c;
                     up_in   = 1'b0;
                     if (pos_x > cnt_x) begin
                        status_in = ST_RANGE;
                        state_in  = S_DONE;
                     end else if (count_ff == CW'(CAPACITY)) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end
                  end
                  OP_DELETE, OP_RETRIEVE: begin
                     ptr_in  = pos_x[AW-1:0] - 1'b1;
                     left_in = (req_op == OP_DELETE) ? (count_ff - pos_c + 1'b1)
                                                     : CW'(1);
                     up_in   = 1'b1;
                     if (req_pos == '0 || pos_x > cnt_x) begin
                        status_in = ST_RANGE;
                        state_in  = S_DONE;
                     end
                  end
                  default: begin
                     ptr_in  = '0;
                     left_in = count_ff;
                     up_in   = 1'b1;
                  end
               endcase
            end
         end
         S_WALK: begin
            // consume the word read last cycle
            if (rdv_ff) begin
               head_in = 1'b0;
               unique case (op_ff)
                  OP_INSERT: begin
                     mem_we    = 1'b1;
                     mem_waddr = rdaddr_ff + 1'b1;
                  end
                  OP_DELETE: begin
                     if (head_ff) begin
                        rd_in = mem_rdata;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = rdaddr_ff - 1'b1;
                     end
                  end
                  OP_LOCATE: begin
                     if (match) begin
                        found_in = rdaddr_c + 1'b1;
                     end
                  end
                  default: begin
                     rd_in = mem_rdata;
                  end
               endcase
            end
            priority if (match) begin
               left_in  = '0;
               state_in = S_DONE;
            end else if (left_ff != '0) begin
               rdv_in    = 1'b1;
               rdaddr_in = ptr_ff;
               ptr_in    = up_ff ? (ptr_ff + 1'b1) : (ptr_ff - 1'b1);
               left_in   = left_ff - 1'b1;
            end else if (!rdv_ff) begin
               if (op_ff == OP_INSERT) begin
                  state_in = S_FIN;
               end else begin
                  if (op_ff == OP_DELETE) begin
                     count_in = count_ff - 1'b1;
                  end
                  state_in = S_DONE;
               end
            end else begin
               // last word still being consumed
               state_in = S_WALK;
            end
         end
         S_FIN: begin
            mem_we    = 1'b1;
            mem_waddr = wpos_ff;
            mem_wdata = val_ff;
            count_in  = count_ff + 1'b1;
            state_in  = S_DONE;
         end
         default: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rdv_ff   <= rdv_in;
      end
      op_ff     <= op_in;
      wpos_ff   <= wpos_in;
      val_ff    <= val_in;
      ptr_ff    <= ptr_in;
      left_ff   <= left_in;
      up_ff     <= up_in;
      head_ff   <= head_in;
      rdaddr_ff <= rdaddr_in;
      rd_ff     <= rd_in;
      found_ff  <= found_in;
      status_ff <= status_in;
   end

   always_comb begin
      found_x          = '0;
      found_x[CW-1:0]  = found_ff;
      res.read_value     = rd_ff;
      res.found_position = found_x[POS_W-1:0];
      res.status         = status_ff;
      res.item_count     = cnt_x[CNT_W-1:0];
      res.is_empty       = (count_ff == '0);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);

endmodule

>>> rtl/positional_list_table.sv
// positional_list_table: top level, request/response streams around the list sequencer.
// Depends on plt_pkg, plt_ram and plt_ctrl.
//
//   channel | direction | tdata (low bit up)                               | tuser
//   req_    | in        | position[4:0], item_value[36:5], zeros to 40     | op
//   rsp_    | out       | read_value[31:0], found_position[36:32],         | status
//           |           | item_count[41:37], is_empty[42], zeros to 48     |
//
// One item at a time: the store is walked entry by entry, shifting entries for insert
// and delete, scanning for locate until the first hit, and reading the one entry for
// retrieve; a rejected item skips the walk. The walk goes entry by entry because the
// store has a single read and a single write port.
// Reset clears the item count; the store holds no valid bits and needs no sweep.
// A finished result sits in the output register, so the next request is taken
// while rsp_tready is low; a second result then waits inside the sequencer.
module positional_list_table
   import plt_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // position[4:0], item_value[36:5]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // read_value, found_position, item_count, is_empty
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic             mem_we;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   logic [VAL_W-1:0] mem_wdata, mem_rdata;
   logic             res_valid, res_ready;
   plt_rsp_type      res;

   logic             rsp_valid_ff, rsp_valid_in;
   plt_rsp_type      rsp_data_ff, rsp_data_in;

   plt_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (VAL_W),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   plt_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser),
      .req_pos   (req_tdata[4:0]),
      .req_val   (req_tdata[36:5]),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // output register is free when empty or when its transfer completes now
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {5'b0, rsp_data_ff.is_empty, rsp_data_ff.item_count,
                        rsp_data_ff.found_position, rsp_data_ff.read_value};

   a_busy_while_result : assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !req_tready)
      else $error("request taken while a result is pending in the sequencer");

   a_error_zero_payload : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != ST_OK) |->
         (rsp_data_ff.read_value == '0 && rsp_data_ff.found_position == '0))
      else $error("rejected operation returned payload");

   a_empty_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.is_empty) |-> (rsp_data_ff.item_count == '0))
      else $error("empty flag with non-zero item count");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request channel ready in the cycle after a request transfer");

endmodule

>>> dv/positional_list_table_tb.sv
// positional_list_table_tb: self-checking bench for the positional list table.
// Queues list operations through a stream driver and checks every response against
// an in-bench shadow list. Depends on plt_pkg and the positional_list_table RTL.
module positional_list_table_tb
   import plt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY    = 16;
   localparam int RAND_ITEMS  = 1000;
   localparam int SEGMENT_LEN = 40;
   localparam int IDLE_PCT    = 29;
   localparam int HOLD_AT     = 400;
   localparam int HOLD_CYCLES = 300;

   typedef enum int { MODE_GROW, MODE_SHRINK, MODE_MIXED } traffic_mode_type;

   typedef struct {
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] item_value;
   } list_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // position[4:0], item_value[36:5]
   logic [1:0]  req_tuser = '0;   // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // read_value, found_position, item_count, is_empty
   logic [1:0]  rsp_tuser;        // status[1:0]

   list_req_type pending_reqs[$];
   plt_rsp_type  expected_rsps[$];
   list_req_type bus_req;

   logic [VAL_W-1:0] shadow_list[CAPACITY];
   int          shadow_count = 0;
   int          gen_count = 0;
   int          mismatches = 0;
   int          cycle_count = 0;
   int          rsp_seen = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;

   positional_list_table #(.CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // no idling on either side inside this window
   function automatic bit quiet_window();
      return cycle_count >= 2000 && cycle_count < 5000;
   endfunction

   function automatic bit idle_now();
      return !quiet_window() && ($urandom_range(0, 99) < IDLE_PCT);
   endfunction

   // shadow list update; returns the response the block should give
   function automatic plt_rsp_type apply_list_op(input list_req_type r);
      plt_rsp_type rsp;
      int          i;
      bit          hit;
      rsp = '0;
      hit = 1'b0;
      case (r.op)
         OP_INSERT: begin
            if (r.position > shadow_count) begin
               rsp.status = ST_RANGE;
            end else if (shadow_count >= CAPACITY) begin
               rsp.status = ST_FULL;
            end else begin
               for (i = shadow_count; i > r.position; i--)
                  shadow_list[i] = shadow_list[i-1];
               shadow_list[r.position] = r.item_value;
               shadow_count++;
            end
         end
         OP_DELETE: begin
            if (r.position < 1 || r.position > shadow_count) begin
               rsp.status = ST_RANGE;
            end else begin
               rsp.read_value = shadow_list[r.position-1];
               for (i = r.position; i < shadow_count; i++)
                  shadow_list[i-1] = shadow_list[i];
               shadow_count--;
            end
         end
         OP_LOCATE: begin
            for (i = 0; i < shadow_count; i++) begin
               if (!hit && shadow_list[i] == r.item_value) begin
                  rsp.found_position = POS_W'(i + 1);
                  hit = 1'b1;
               end
            end
         end
         default: begin
            if (r.position < 1 || r.position > shadow_count)
               rsp.status = ST_RANGE;
            else
               rsp.read_value = shadow_list[r.position-1];
         end
      endcase
      rsp.item_count = CNT_W'(shadow_count);
      rsp.is_empty   = (shadow_count == 0);
      return rsp;
   endfunction

   // tracks the count at generation time so that positions can be made legal
   task automatic queue_req(input logic [OP_W-1:0] op, input int pos,
                            input logic [VAL_W-1:0] val);
      list_req_type r;
      r.op         = op;
      r.position   = POS_W'(pos);
      r.item_value = val;
      pending_reqs.push_back(r);
      if (op == OP_INSERT && r.position <= gen_count && gen_count < CAPACITY)
         gen_count++;
      else if (op == OP_DELETE && r.position >= 1 && r.position <= gen_count)
         gen_count--;
   endtask

   // small pool so that locate finds matches, plus extremes and full-range noise
   function automatic logic [VAL_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5)
         return VAL_W'($urandom_range(0, 7));
      else if (sel == 5)
         case ($urandom_range(0, 2))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            default: return 32'hFFFF_FFFF;
         endcase
      else
         return $urandom;
   endfunction

   task automatic queue_random(input traffic_mode_type mode);
      int               roll;
      logic [OP_W-1:0]  op;
      int               pos;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_GROW:   op = (roll < 80) ? OP_INSERT : (roll < 85) ? OP_DELETE :
                           (roll < 93) ? OP_LOCATE : OP_RETRIEVE;
         MODE_SHRINK: op = (roll < 70) ? OP_DELETE : (roll < 80) ? OP_INSERT :
                           (roll < 90) ? OP_LOCATE : OP_RETRIEVE;
         default:     op = OP_W'($urandom_range(0, 3));
      endcase
      if ($urandom_range(0, 9) == 0)
         pos = $urandom_range(0, 31);
      else if (op == OP_INSERT)
         pos = $urandom_range(0, gen_count);
      else if (gen_count > 0)
         pos = $urandom_range(1, gen_count);
      else
         pos = $urandom_range(0, 2);
      queue_req(op, pos, pick_value());
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         mismatches++;
      end
   endtask

   // driver: one transfer per handshake, next item offered on the same edge
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rsps.push_back(apply_list_op(bus_req));
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 && !idle_now()) begin
               bus_req    = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {3'b000, bus_req.item_value, bus_req.position};
               req_tuser  <= bus_req.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each transfer with the oldest expectation
   always @(posedge clock) begin
      plt_rsp_type exp_rsp;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen <= rsp_seen + 1;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h/%h",
                        $time, rsp_tdata, rsp_tuser);
               mismatches++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               check_field("read_value", exp_rsp.read_value, rsp_tdata[31:0]);
               check_field("found_position", 32'(exp_rsp.found_position), 32'(rsp_tdata[36:32]));
               check_field("status", 32'(exp_rsp.status), 32'(rsp_tuser));
               check_field("item_count", 32'(exp_rsp.item_count), 32'(rsp_tdata[41:37]));
               check_field("is_empty", 32'(exp_rsp.is_empty), 32'(rsp_tdata[42]));
            end
         end
         // one long back-pressure stretch so the block fills and stalls its input
         if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!hold_done && rsp_seen >= HOLD_AT) begin
            hold_done  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !idle_now();
         end
      end
   end

   initial begin
      traffic_mode_type mode;
      int               n;
      // empty list: range errors and locate miss
      queue_req(OP_RETRIEVE, 1, 32'h0);
      queue_req(OP_DELETE, 0, 32'h0);
      queue_req(OP_LOCATE, 0, 32'h0);
      queue_req(OP_INSERT, 1, 32'h1111_1111);
      // inserts at front, end and middle with extreme values
      queue_req(OP_INSERT, 0, 32'h8000_0000);
      queue_req(OP_INSERT, 1, 32'h7FFF_FFFF);
      queue_req(OP_INSERT, 1, 32'h0000_0000);
      queue_req(OP_INSERT, 0, 32'hFFFF_FFFF);
      queue_req(OP_LOCATE, 31, 32'h7FFF_FFFF);
      queue_req(OP_LOCATE, 0, 32'h1234_5678);
      queue_req(OP_RETRIEVE, 4, 32'h0);
      queue_req(OP_RETRIEVE, 5, 32'h0);
      queue_req(OP_RETRIEVE, 0, 32'h0);
      queue_req(OP_RETRIEVE, 31, 32'hFFFF_FFFF);
      queue_req(OP_INSERT, 31, 32'h5555_AAAA);
      queue_req(OP_DELETE, 4, 32'h0);
      queue_req(OP_DELETE, 1, 32'h0);
      queue_req(OP_DELETE, 3, 32'h0);
      queue_req(OP_LOCATE, 0, 32'h8000_0000);
      queue_req(OP_DELETE, 1, 32'h0);
      queue_req(OP_DELETE, 1, 32'h0);
      queue_req(OP_DELETE, 1, 32'h0);
      // random traffic in segments that grow, drain or churn the list
      mode = MODE_GROW;
      for (n = 0; n < RAND_ITEMS; n++) begin
         if (n % SEGMENT_LEN == 0 && n != 0)
            mode = traffic_mode_type'($urandom_range(0, 2));
         queue_random(mode);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> files.f
rtl/plt_pkg.sv
rtl/plt_ram.sv
rtl/plt_ctrl.sv
rtl/positional_list_table.sv
dv/positional_list_table_tb.sv
